// ===== sv/cir_pkg.sv =====
package cir_pkg;

	// default sizes, handed to the top level parameters
	localparam int SAMPLE_BITS_DEF      = 24;
	localparam int PHASE_INDEX_BITS_DEF = 12;
	localparam int MAX_DIVIDE_DEF       = 64;

	// register and datapath widths fixed by the interface
	localparam int PHASE_BITS    = 24;
	localparam int STEP_BITS     = 25;
	localparam int DIVIDE_BITS   = 7;
	localparam int INVERSE_BITS  = 17;
	localparam int GAIN_BITS     = 16;
	localparam int CFG_DATA_BITS = 25;
	localparam int CFG_INDEX_BITS = 2;

	// fixed-point formats
	localparam int INV_FRAC    = 16;
	localparam int WEIGHT_FRAC = 17;
	localparam int WEIGHT_BITS = 18;
	localparam int WEIGHT_ONE  = 131072;
	localparam int GAIN_FRAC   = 12;

	// outputs per point are capped
	localparam int OUT_CAP  = 64;
	localparam int CAP_BITS = 6;

	// divide compare width covers any legal group size
	localparam int DIV_CMP_BITS = 9;

	// point queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// floor(y / 3) = (y * THIRD_RECIP) >> THIRD_SHIFT for y below 2^17
	localparam int          THIRD_BITS  = 17;
	localparam logic [16:0] THIRD_RECIP = 17'd43691;
	localparam int          THIRD_SHIFT = 17;

	// reset values of the registers
	localparam logic [STEP_BITS-1:0]    STEP_RESET    = 25'h1000000;
	localparam logic [DIVIDE_BITS-1:0]  DIVIDE_RESET  = 7'd1;
	localparam logic [INVERSE_BITS-1:0] INVERSE_RESET = 17'h10000;
	localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = 16'h1000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_STEP           = 2'd0,
		REG_SOURCE_DIVIDE  = 2'd1,
		REG_INVERSE_DIVIDE = 2'd2,
		REG_GAIN           = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_BITS-1:0]    step;
		logic [DIVIDE_BITS-1:0]  source_divide;
		logic [INVERSE_BITS-1:0] inverse_divide;
		logic [GAIN_BITS-1:0]    gain;
	} cfg_t;

endpackage

// ===== sv/cir_fifo.sv =====
module cir_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   level_q;

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign full      = (level_q == (PTR_W+1)'(DEPTH));

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				level_q <= level_q + (PTR_W+1)'(1);
			else if (pop && !push)
				level_q <= level_q - (PTR_W+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/cir_front.sv =====
module cir_front
	import cir_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_DIVIDE  = MAX_DIVIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] push_data,
	input  logic                          queue_full
);

	localparam int CNT_W  = (MAX_DIVIDE > 1) ? $clog2(MAX_DIVIDE) : 1;
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_DIVIDE);
	localparam int PROD_W = SUM_W + INVERSE_BITS + 1;

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (INV_FRAC - 1);
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SUM_W-1:0]  group_sum_q;
	logic [CNT_W-1:0]         count_q;
	logic                     v_s1;
	logic                     v_s2;
	logic signed [SUM_W-1:0]  tot_s1;
	logic signed [PROD_W-1:0] prod_s2;

	logic [DIV_CMP_BITS-1:0]  div_eff;
	logic [DIV_CMP_BITS-1:0]  cnt_next;
	logic                     complete;
	logic signed [SUM_W-1:0]  sum_next;
	logic                     accept;
	logic                     fen;
	logic signed [PROD_W-1:0] rnd_full;

	// the front stalls only when a finished point cannot enter the queue
	assign fen      = !v_s2 || !queue_full;
	assign in_ready = fen;
	assign accept   = in_valid && in_ready;
	assign push     = v_s2 && !queue_full;

	// effective group size: zero acts as one, clamp at the maximum
	always_comb begin
		div_eff = DIV_CMP_BITS'(cfg.source_divide);
		if (cfg.source_divide == '0)
			div_eff = DIV_CMP_BITS'(1);
		else if (DIV_CMP_BITS'(cfg.source_divide) > DIV_CMP_BITS'(MAX_DIVIDE))
			div_eff = DIV_CMP_BITS'(MAX_DIVIDE);
	end

	assign cnt_next = DIV_CMP_BITS'(count_q) + DIV_CMP_BITS'(1);
	assign complete = (cnt_next >= div_eff);
	assign sum_next = group_sum_q + SUM_W'(in_sample);

	// group accumulation and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_sum_q <= '0;
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else if (fen) begin
			v_s1 <= accept && complete;
			v_s2 <= v_s1;
			if (accept) begin
				if (complete) begin
					group_sum_q <= '0;
					count_q     <= '0;
				end else begin
					group_sum_q <= sum_next;
					count_q     <= CNT_W'(cnt_next);
				end
			end
		end
	end

	// group total, then scale by the reciprocal
	always_ff @(posedge clk) begin
		if (fen) begin
			if (accept && complete)
				tot_s1 <= sum_next;
			if (v_s1)
				prod_s2 <= PROD_W'(tot_s1) * PROD_W'(signed'({1'b0, cfg.inverse_divide}));
		end
	end

	// round half up and saturate into a point
	assign rnd_full = (prod_s2 + HALF) >>> INV_FRAC;

	always_comb begin
		if (rnd_full > PROD_W'(S_MAX))
			push_data = S_MAX;
		else if (rnd_full < PROD_W'(S_MIN))
			push_data = S_MIN;
		else
			push_data = rnd_full[SAMPLE_BITS-1:0];
	end

endmodule

// ===== sv/cir_back.sv =====
module cir_back
	import cir_pkg::*;
#(
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
	parameter int PHASE_INDEX_BITS = PHASE_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          point_valid,
	input  logic signed [SAMPLE_BITS-1:0] point,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          last
);

	localparam int P      = PHASE_INDEX_BITS;
	localparam int N_CNT  = 1 << P;
	localparam int SH     = 3 * P - 16;
	localparam int BIAS_SH = 3 * P - 17;
	localparam int M_W    = 3 * P + 3;
	localparam int T_W    = 2 * THIRD_BITS + 1;
	localparam int PR_W   = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int ACC_W  = PR_W + 2;
	localparam int V_W    = ACC_W - WEIGHT_FRAC;
	localparam int G_W    = V_W + GAIN_BITS + 1;
	localparam int NSTG   = 8;

	localparam logic [P-1:0] C_HALF = {1'b1, {(P-1){1'b0}}};
	localparam logic [M_W:0] F0_BIAS = (M_W+1)'(3) << BIAS_SH;
	localparam logic [M_W:0] F1_BIAS = (M_W+1)'(1) << BIAS_SH;
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (WEIGHT_FRAC - 1);
	localparam logic signed [G_W-1:0]   G_HALF   = G_W'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// control state
	logic [PHASE_BITS-1:0]         phase_q;
	logic [CAP_BITS-1:0]           count_q;
	logic signed [SAMPLE_BITS-1:0] window_q [4];
	logic [NSTG:1]                 vld_q;
	logic                          out_valid_q;

	// issue
	logic                  en;
	logic                  issue;
	logic [P-1:0]          c;
	logic [PHASE_BITS+1:0] phase_sum;
	logic                  carry;
	logic                  last_issue;
	logic                  c_lt;
	logic                  c_eq;
	logic [P:0]            nc_d;

	// stage 1: operands of the weight polynomials
	logic [P-1:0]  c_s1;
	logic [P:0]    nc_s1;
	logic [P:0]    npc_s1;
	logic [P+1:0]  tnmc_s1;
	logic [P-1:0]  a_s1;
	logic          lt_s1, eq_s1, last_s1;
	logic signed [SAMPLE_BITS-1:0] win_s1 [4];

	// stage 2: first products
	logic [2*P:0]   p1_s2;
	logic [2*P+2:0] q_s2;
	logic [P:0]     npc_s2;
	logic [P+1:0]   tnmc_s2;
	logic [P-1:0]   a_s2;
	logic           lt_s2, eq_s2, last_s2;
	logic signed [SAMPLE_BITS-1:0] win_s2 [4];

	// stage 3: cubic numerators
	logic [M_W-1:0] m0c_s3, m0n_s3, n1_s3;
	logic           lt_s3, eq_s3, last_s3;
	logic signed [SAMPLE_BITS-1:0] win_s3 [4];

	// stage 4: scaled numerators, divide by three
	logic [M_W:0]             b0c, b0n, b1;
	logic [T_W-1:0]           t0c_s4, t0n_s4;
	logic [WEIGHT_BITS-1:0]   f1a_s4;
	logic                     lt_s4, eq_s4, last_s4;
	logic signed [SAMPLE_BITS-1:0] win_s4 [4];

	// stage 5: the four weights
	logic [WEIGHT_BITS-1:0]   f0c, f0n;
	logic [WEIGHT_BITS+1:0]   refl;
	logic [WEIGHT_BITS-1:0]   w_d [4];
	logic [WEIGHT_BITS-1:0]   w_s5 [4];
	logic                     last_s5;
	logic signed [SAMPLE_BITS-1:0] win_s5 [4];

	// stages 6 to 8: blend, gain
	logic signed [PR_W-1:0]  pr_s6 [4];
	logic                    last_s6;
	logic signed [ACC_W-1:0] acc_d;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [V_W-1:0]   v_s7;
	logic                    last_s7;
	logic signed [G_W-1:0]   g_s8;
	logic                    last_s8;
	logic signed [G_W-1:0]   y_full;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          last_q;

	// whole pipeline moves when the output register is free or taken
	assign en         = !out_valid_q || out_ready;
	assign issue      = en && point_valid;
	assign c          = phase_q[PHASE_BITS-1 -: P];
	assign phase_sum  = (PHASE_BITS+2)'(phase_q) + (PHASE_BITS+2)'(cfg.step);
	assign carry      = (phase_sum[PHASE_BITS+1:PHASE_BITS] != 2'b00);
	assign last_issue = carry || (count_q == CAP_BITS'(OUT_CAP - 1));
	assign pop        = issue && last_issue;

	assign c_lt = !c[P-1];
	assign c_eq = (c == C_HALF);
	assign nc_d = (P+1)'(N_CNT) - (P+1)'(c);

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign last       = last_q;

	// phase, output count, window and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			count_q     <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++)
				window_q[i] <= '0;
		end else if (en) begin
			vld_q       <= {vld_q[NSTG-1:1], point_valid};
			out_valid_q <= vld_q[NSTG];
			if (issue) begin
				phase_q <= phase_sum[PHASE_BITS-1:0];
				count_q <= last_issue ? '0 : count_q + CAP_BITS'(1);
				if (last_issue) begin
					window_q[0] <= window_q[1];
					window_q[1] <= window_q[2];
					window_q[2] <= window_q[3];
					window_q[3] <= point;
				end
			end
		end
	end

	// stage 4 shifts and stage 5 weight selection
	assign b0c = (M_W+1)'(m0c_s3) + F0_BIAS;
	assign b0n = (M_W+1)'(m0n_s3) + F0_BIAS;
	assign b1  = (M_W+1)'(n1_s3) + F1_BIAS;

	assign f0c  = t0c_s4[THIRD_SHIFT +: WEIGHT_BITS];
	assign f0n  = t0n_s4[THIRD_SHIFT +: WEIGHT_BITS];
	assign refl = (WEIGHT_BITS+2)'(WEIGHT_ONE) + (WEIGHT_BITS+2)'(f0c)
		+ (WEIGHT_BITS+2)'(f0n) - (WEIGHT_BITS+2)'(f1a_s4);

	// the rising curve is computed directly below half way and mirrored above
	always_comb begin
		w_d[0] = f0n;
		w_d[3] = f0c;
		if (eq_s4) begin
			w_d[1] = f1a_s4;
			w_d[2] = f1a_s4;
		end else if (lt_s4) begin
			w_d[1] = refl[WEIGHT_BITS-1:0];
			w_d[2] = f1a_s4;
		end else begin
			w_d[1] = f1a_s4;
			w_d[2] = refl[WEIGHT_BITS-1:0];
		end
	end

	// four-tap blend and gain
	assign acc_d = ACC_W'(pr_s6[1]) + ACC_W'(pr_s6[2]) - ACC_W'(pr_s6[0]) - ACC_W'(pr_s6[3]);
	assign acc_rnd = (acc_d + ACC_HALF) >>> WEIGHT_FRAC;
	assign y_full  = (g_s8 + G_HALF) >>> GAIN_FRAC;

	always_comb begin
		if (y_full > G_W'(S_MAX))
			y_sat = S_MAX;
		else if (y_full < G_W'(S_MIN))
			y_sat = S_MIN;
		else
			y_sat = y_full[SAMPLE_BITS-1:0];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			c_s1    <= c;
			nc_s1   <= nc_d;
			npc_s1  <= (P+1)'(N_CNT) + (P+1)'(c);
			tnmc_s1 <= (P+2)'(2 * N_CNT) - (P+2)'(c);
			a_s1    <= (c_lt || c_eq) ? c : nc_d[P-1:0];
			lt_s1   <= c_lt;
			eq_s1   <= c_eq;
			last_s1 <= last_issue;
			win_s1  <= window_q;
			// s2
			p1_s2   <= (2*P+1)'(c_s1) * (2*P+1)'(nc_s1);
			q_s2    <= (2*P+3)'(npc_s1) * (2*P+3)'(tnmc_s1);
			npc_s2  <= npc_s1;
			tnmc_s2 <= tnmc_s1;
			a_s2    <= a_s1;
			lt_s2   <= lt_s1;
			eq_s2   <= eq_s1;
			last_s2 <= last_s1;
			win_s2  <= win_s1;
			// s3
			m0c_s3  <= M_W'(p1_s2) * M_W'(npc_s2);
			m0n_s3  <= M_W'(p1_s2) * M_W'(tnmc_s2);
			n1_s3   <= M_W'(a_s2) * M_W'(q_s2);
			lt_s3   <= lt_s2;
			eq_s3   <= eq_s2;
			last_s3 <= last_s2;
			win_s3  <= win_s2;
			// s4
			t0c_s4  <= T_W'(b0c[SH +: THIRD_BITS]) * T_W'(THIRD_RECIP);
			t0n_s4  <= T_W'(b0n[SH +: THIRD_BITS]) * T_W'(THIRD_RECIP);
			f1a_s4  <= b1[SH +: WEIGHT_BITS];
			lt_s4   <= lt_s3;
			eq_s4   <= eq_s3;
			last_s4 <= last_s3;
			win_s4  <= win_s3;
			// s5
			w_s5    <= w_d;
			last_s5 <= last_s4;
			win_s5  <= win_s4;
			// s6
			for (int i = 0; i < 4; i++)
				pr_s6[i] <= PR_W'(win_s5[i]) * PR_W'(signed'({1'b0, w_s5[i]}));
			last_s6 <= last_s5;
			// s7
			v_s7    <= acc_rnd[V_W-1:0];
			last_s7 <= last_s6;
			// s8
			g_s8    <= G_W'(v_s7) * G_W'(signed'({1'b0, cfg.gain}));
			last_s8 <= last_s7;
			// output register
			out_sample_q <= y_sat;
			last_q       <= last_s8;
		end
	end

endmodule

// ===== sv/cubic_interp_resampler.sv =====
// Front: takes one word a cycle unless a finished point waits on a full point queue;
// a completed group's total is registered, then scaled and registered as a point.
// Back: one output word per cycle while out_ready is high, so a point that yields k
// outputs (1 to 64) holds the back until its last output has issued.
// Weights are computed per output in the back pipeline (9 stages), so no table load.
// Reset (arst_n, asynchronous): window, phase, group sum, queue and registers to defaults.
module cubic_interp_resampler
	import cir_pkg::*;
#(
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
	parameter int PHASE_INDEX_BITS = PHASE_INDEX_BITS_DEF,
	parameter int MAX_DIVIDE       = MAX_DIVIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [CFG_INDEX_BITS-1:0]     wr_index,
	input  logic [CFG_DATA_BITS-1:0]      wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	output logic                          last
);

	cfg_t cfg_q;

	logic                          push;
	logic signed [SAMPLE_BITS-1:0] push_data;
	logic                          pop;
	logic [SAMPLE_BITS-1:0]        q_data;
	logic                          q_valid;
	logic                          q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step           <= STEP_RESET;
			cfg_q.source_divide  <= DIVIDE_RESET;
			cfg_q.inverse_divide <= INVERSE_RESET;
			cfg_q.gain           <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_STEP:           cfg_q.step           <= wr_data[STEP_BITS-1:0];
				REG_SOURCE_DIVIDE:  cfg_q.source_divide  <= wr_data[DIVIDE_BITS-1:0];
				REG_INVERSE_DIVIDE: cfg_q.inverse_divide <= wr_data[INVERSE_BITS-1:0];
				REG_GAIN:           cfg_q.gain           <= wr_data[GAIN_BITS-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// group averaging
	cir_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_DIVIDE  (MAX_DIVIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.push       (push),
		.push_data  (push_data),
		.queue_full (q_full)
	);

	// point queue
	cir_fifo #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (q_data),
		.not_empty (q_valid),
		.full      (q_full)
	);

	// interpolation and output
	cir_back #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.PHASE_INDEX_BITS (PHASE_INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.point_valid (q_valid),
		.point       (q_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.last        (last)
	);

	// the back retires a point only while the queue holds one
	a_pop_has_point: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("point retired from an empty queue");

	// a point is never pushed into a full queue
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("point pushed into a full queue");

	// input stalls only because the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled with room in the queue");

endmodule

// ===== tb/sv/cubic_interp_resampler_tb.sv =====
module cubic_interp_resampler_tb;
	import cir_pkg::*;

	localparam int SW             = SAMPLE_BITS_DEF;
	localparam int ROM_N          = 1 << PHASE_INDEX_BITS_DEF;
	localparam int CLK_HALF       = 6;
	localparam int CLK_PERIOD     = 2 * CLK_HALF;
	localparam int RESET_CYCLES   = 6;
	localparam int IDLE_PCT       = 22;
	localparam int RANDOM_ITEMS   = 200;
	localparam int DRAIN_CYCLES   = 32;
	localparam int SETTLE_LIMIT   = 5000;
	localparam int MAX_PRINTS     = 40;
	localparam int TIMEOUT_CYCLES = 1000000;

	localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 last;
	} out_word_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_KNOWN
	} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		cfg_reg_t                 idx;
		logic [CFG_DATA_BITS-1:0] value;
		logic signed [SW-1:0]     sample;
		logic signed [SW-1:0]     known;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [CFG_INDEX_BITS-1:0] wr_index;
	logic [CFG_DATA_BITS-1:0]  wr_data;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [SW-1:0]      in_sample;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [SW-1:0]      out_sample;
	logic                      last;

	// predictor state and register shadow
	cfg_t            shadow;
	longint signed   win [4];
	logic [PHASE_BITS-1:0] ph;
	longint signed   gsum;
	int unsigned     gcount;
	longint signed   curve0 [0:ROM_N];
	longint signed   curve1 [0:ROM_N];

	out_word_t pending_words [$];
	stim_row_t plan [$];
	int        mismatches;
	bit        calm;

	cubic_interp_resampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sample(out_sample),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic longint signed round_shift(longint signed x, int n);
		return (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint signed clamp_sample(longint signed x);
		if (x > SAT_HI)
			return SAT_HI;
		if (x < SAT_LO)
			return SAT_LO;
		return x;
	endfunction

	// one source word into the group; a finished group emits its output words
	task automatic feed_sample(input logic signed [SW-1:0] s, input bit keep);
		int unsigned         dv;
		int unsigned         c;
		int unsigned         nc;
		int                  cnt;
		longint signed       pt;
		longint signed       acc;
		longint signed       v;
		logic [PHASE_BITS+1:0] sum;
		bit                  done;
		out_word_t           w;
		dv = shadow.source_divide;
		if (dv == 0)
			dv = 1;
		if (dv > MAX_DIVIDE_DEF)
			dv = MAX_DIVIDE_DEF;
		gsum += s;
		gcount++;
		if (gcount < dv)
			return;
		pt = clamp_sample(round_shift(gsum * longint'(shadow.inverse_divide), INV_FRAC));
		gsum = 0;
		gcount = 0;
		cnt = 0;
		do begin
			c = ph >> (PHASE_BITS - PHASE_INDEX_BITS_DEF);
			nc = ROM_N - c;
			acc = -win[0] * curve0[nc] + win[1] * curve1[nc]
			      + win[2] * curve1[c] - win[3] * curve0[c];
			v = round_shift(acc, WEIGHT_FRAC);
			w.sample = SW'(clamp_sample(round_shift(v * longint'(shadow.gain), GAIN_FRAC)));
			sum = ph + shadow.step;
			ph = sum[PHASE_BITS-1:0];
			cnt++;
			// carry out of the phase, or the output cap, closes the loop
			done = (sum >= (1 << PHASE_BITS)) || (cnt >= OUT_CAP);
			w.last = done;
			if (keep)
				pending_words.push_back(w);
		end while (!done);
		win[0] = win[1];
		win[1] = win[2];
		win[2] = win[3];
		win[3] = pt;
	endtask

	// drop valid, wait for all expected words, then let the pipeline run dry
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_words.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_words.size() != 0) begin
			flag_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
			pending_words.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] v);
		settle();
		wr_en <= 1'b1;
		wr_index <= r;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (r)
			REG_STEP:           shadow.step = v[STEP_BITS-1:0];
			REG_SOURCE_DIVIDE:  shadow.source_divide = v[DIVIDE_BITS-1:0];
			REG_INVERSE_DIVIDE: shadow.inverse_divide = v[INVERSE_BITS-1:0];
			REG_GAIN:           shadow.gain = v[GAIN_BITS-1:0];
		endcase
	endtask

	// present one word, random gaps first, hold until taken
	task automatic send_sample(input logic signed [SW-1:0] s, input bit keep);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_sample <= s;
		do @(posedge clk); while (!in_ready);
		feed_sample(s, keep);
	endtask

	function automatic logic signed [SW-1:0] draw_sample();
		int v;
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3, 4: begin
				v = int'($urandom_range(0, 131071)) - 65536;
				return v[SW-1:0];
			end
			default: return SW'($urandom());
		endcase
	endfunction

	function automatic void put_write(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
		plan.push_back('{kind: ROW_WRITE, idx: r, value: v, sample: '0, known: '0});
	endfunction

	function automatic void put_sample(logic signed [SW-1:0] s);
		plan.push_back('{kind: ROW_SAMPLE, idx: REG_STEP, value: '0, sample: s, known: '0});
	endfunction

	function automatic void put_known(logic signed [SW-1:0] s, logic signed [SW-1:0] k);
		plan.push_back('{kind: ROW_KNOWN, idx: REG_STEP, value: '0, sample: s, known: k});
	endfunction

	// output side: check each taken word, then pick next ready
	initial begin : sink
		out_word_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					flag_mismatch($sformatf("unexpected word %0d last %0b", out_sample, last));
				end else begin
					want = pending_words.pop_front();
					if (out_sample !== want.sample)
						flag_mismatch($sformatf("out_sample %0d, want %0d", out_sample,
							want.sample));
					if (last !== want.last)
						flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
				end
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : stimulus
		longint unsigned n;
		longint unsigned n3;
		longint unsigned k;
		longint unsigned num;
		int unsigned     phase_no;
		int unsigned     random_items;
		int unsigned     d;
		int unsigned     eff;
		int unsigned     n_items;
		logic [CFG_DATA_BITS-1:0] st;
		logic [CFG_DATA_BITS-1:0] inv;
		logic [CFG_DATA_BITS-1:0] g;

		wr_en <= 1'b0;
		wr_index <= REG_STEP;
		wr_data <= '0;
		in_valid <= 1'b0;
		in_sample <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		mismatches = 0;

		// weight curves, Q1.17, exact integer rounding half up
		n = ROM_N;
		n3 = n * n * n;
		for (int i = 0; i <= ROM_N; i++) begin
			k = i;
			num = k * n * n - k * k * k;
			curve0[i] = (num * WEIGHT_ONE + 3 * n3) / (6 * n3);
		end
		for (int i = 0; i <= ROM_N / 2; i++) begin
			k = i;
			num = 2 * k * n * n + k * k * n - k * k * k;
			curve1[i] = (num * WEIGHT_ONE + n3) / (2 * n3);
		end
		for (int i = ROM_N / 2 + 1; i < ROM_N; i++)
			curve1[i] = WEIGHT_ONE + curve0[i] + curve0[ROM_N - i] - curve1[ROM_N - i];
		curve0[0] = 0;
		curve0[ROM_N] = 0;
		curve1[0] = 0;
		curve1[ROM_N] = WEIGHT_ONE;

		shadow = '{STEP_RESET, DIVIDE_RESET, INVERSE_RESET, GAIN_RESET};
		for (int i = 0; i < 4; i++)
			win[i] = 0;
		ph = '0;
		gsum = 0;
		gcount = 0;

		// reset defaults: one word per input, the input three words late
		put_known(SAMPLE_MAX, '0);
		put_known(SAMPLE_MIN, '0);
		put_known('0, '0);
		put_known(24'sd1, SAMPLE_MAX);
		put_known(-24'sd1, SAMPLE_MIN);
		put_known(24'sh555555, '0);
		put_known(24'shAAAAAA, 24'sd1);
		// zero gain silences everything
		put_write(REG_GAIN, 25'd0);
		put_known(24'sh123456, '0);
		put_known(-24'sd1, '0);
		// full gain saturates
		put_write(REG_GAIN, 25'd65535);
		put_sample(SAMPLE_MAX);
		put_sample(SAMPLE_MIN);
		put_write(REG_GAIN, 25'd4096);
		// from phase zero: two outputs, exactly 64 on a carry, the cap twice,
		// then a step above one point
		put_write(REG_STEP, 25'h0800000);
		put_sample(24'sd4000000);
		put_write(REG_STEP, 25'd262144);
		put_sample(-24'sd3000000);
		put_write(REG_STEP, 25'd0);
		put_sample(24'sd2500000);
		put_write(REG_STEP, 25'd5000);
		put_sample(24'sd1234567);
		put_write(REG_STEP, 25'h1FFFFFF);
		put_sample(-24'sd7000000);
		put_write(REG_STEP, 25'h1000000);
		// divide of zero acts as one
		put_write(REG_SOURCE_DIVIDE, 25'd0);
		put_sample(SAMPLE_MAX);
		// groups of three
		put_write(REG_SOURCE_DIVIDE, 25'd3);
		put_write(REG_INVERSE_DIVIDE, 25'd21845);
		put_sample(24'sd3000000);
		put_sample(-24'sd1000000);
		put_sample(24'sd7);
		// divide lowered mid-group closes the group on the next word
		put_write(REG_SOURCE_DIVIDE, 25'd4);
		put_sample(24'sd500000);
		put_sample(24'sd600000);
		put_write(REG_SOURCE_DIVIDE, 25'd2);
		put_sample(-24'sd700000);
		// inverse of zero, then an oversized inverse that saturates the average
		put_write(REG_SOURCE_DIVIDE, 25'd1);
		put_write(REG_INVERSE_DIVIDE, 25'd0);
		put_sample(24'sd4444444);
		put_write(REG_INVERSE_DIVIDE, 25'd131071);
		put_sample(SAMPLE_MAX);
		put_sample(SAMPLE_MIN);
		put_write(REG_INVERSE_DIVIDE, 25'h10000);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WRITE: write_reg(plan[i].idx, plan[i].value);
				ROW_SAMPLE: send_sample(plan[i].sample, 1'b1);
				ROW_KNOWN: begin
					send_sample(plan[i].sample, 1'b0);
					pending_words.push_back('{plan[i].known, 1'b1});
				end
			endcase
		end

		// random phases, each with its own register setting
		phase_no = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase_no == 1)
				d = $urandom_range(1) ? 127 : 64;
			else if ($urandom_range(5) == 0)
				d = $urandom_range(0, 12);
			else
				d = $urandom_range(1, 3);
			eff = (d == 0) ? 1 : ((d > MAX_DIVIDE_DEF) ? MAX_DIVIDE_DEF : d);
			case ($urandom_range(9))
				0: st = 25'h1FFFFFF;
				1: st = $urandom_range(0, 262143);
				2: st = 25'd262144;
				3: st = 25'h1000000;
				default: st = $urandom_range(262144, 16777216);
			endcase
			if ($urandom_range(7) == 0)
				inv = $urandom_range(0, 131071);
			else
				inv = (65536 + eff / 2) / eff;
			case ($urandom_range(7))
				0: g = 25'd0;
				1: g = 25'd65535;
				2, 3: g = $urandom_range(0, 65535);
				default: g = 25'd4096;
			endcase
			write_reg(REG_STEP, st);
			write_reg(REG_SOURCE_DIVIDE, d);
			write_reg(REG_INVERSE_DIVIDE, inv);
			write_reg(REG_GAIN, g);
			// one phase runs flat out on both sides
			calm = (phase_no == 3);
			n_items = (eff > 8) ? 2 * eff + $urandom_range(0, 4) : $urandom_range(16, 28);
			repeat (n_items) begin
				send_sample(draw_sample(), 1'b1);
				random_items++;
			end
			phase_no++;
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cir_pkg.sv
sv/cir_fifo.sv
sv/cir_front.sv
sv/cir_back.sv
sv/cubic_interp_resampler.sv
tb/sv/cubic_interp_resampler_tb.sv
